>>> design/sfga_pkg.sv
// shared types, constants and sine table for the structure factor accumulator
package sfga_pkg;

  localparam int SINE_BITS = 12;
  localparam int TAB_SH    = 16 - SINE_BITS;
  localparam int QTAB_N    = (1 << (SINE_BITS - 2)) + 1;
  localparam int QTAB_AW   = SINE_BITS - 1;
  localparam int TIDX_W    = SINE_BITS - 2;
  localparam int ACC_DEPTH = 64;
  localparam int ACC_AW    = 6;
  localparam int ACC_W     = 32;
  localparam int MAG_W     = 64;
  localparam int POWER_W   = 60;
  localparam logic [MAG_W-1:0] POWER_MAX = 64'h0FFF_FFFF_FFFF_FFFF;

  typedef logic [14:0] qtab_t [QTAB_N];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_RD,
    ST_SQ,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  function automatic logic [14:0] quarter_sine(longint unsigned t);
    longint unsigned theta;
    longint unsigned th2;
    longint unsigned term;
    longint unsigned s;
    longint unsigned q;
    theta = (t * 64'd6746518852) >> 16;
    th2 = (theta * theta) >> 30;
    term = 64'd1073741824;
    term = 64'd1073741824 - ((th2 * term) >> 30) / 64'd110;
    term = 64'd1073741824 - ((th2 * term) >> 30) / 64'd72;
    term = 64'd1073741824 - ((th2 * term) >> 30) / 64'd42;
    term = 64'd1073741824 - ((th2 * term) >> 30) / 64'd20;
    term = 64'd1073741824 - ((th2 * term) >> 30) / 64'd6;
    s = (theta * term) >> 30;
    q = (s + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k < QTAB_N; k++) begin
      tab[k] = quarter_sine(longint'(k) << TAB_SH);
    end
    return tab;
  endfunction

  localparam qtab_t SINE_QTAB = build_qtab();

endpackage

>>> design/sfga_if.sv
// particle and grid point channel interfaces
interface sfga_in_if;
  logic               valid;
  logic               ready;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic               last_particle;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, last_particle, input ready);
  modport sink (input valid, pos_x, pos_y, vel_x, vel_y, last_particle, output ready);
endinterface

interface sfga_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         grid_ix;
  logic [2:0]         grid_iy;
  logic signed [31:0] sum_re;
  logic signed [31:0] sum_im;
  logic [59:0]        power;
  logic               overflow;
  logic               last;
  modport source (output valid, grid_ix, grid_iy, sum_re, sum_im, power, overflow, last,
                  input ready);
  modport sink (input valid, grid_ix, grid_iy, sum_re, sum_im, power, overflow, last,
                output ready);
endinterface

>>> design/sfga_ram.sv
// generic single write port ram with registered read
module sfga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> design/sfga_sine_rom.sv
// quarter wave sine rom with two registered read ports
module sfga_sine_rom (
  input  logic                        clk,
  input  logic [sfga_pkg::QTAB_AW-1:0] addr_a,
  input  logic [sfga_pkg::QTAB_AW-1:0] addr_b,
  output logic [14:0]                 data_a,
  output logic [14:0]                 data_b
);
  import sfga_pkg::*;

  always_ff @(posedge clk) begin
    data_a <= SINE_QTAB[addr_a];
    data_b <= SINE_QTAB[addr_b];
  end
endmodule

>>> design/sfga_div.sv
// restoring divider, one quotient bit per cycle
module sfga_div #(
  parameter int DEN_W = 13
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sfga_pkg::MAG_W-1:0] num,
  input  logic [DEN_W-1:0]           den,
  output logic                       done,
  output logic [sfga_pkg::MAG_W-1:0] quo
);
  import sfga_pkg::*;

  localparam int CW = $clog2(MAG_W);

  logic [DEN_W-1:0] rem_r;
  logic [MAG_W-1:0] quo_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign diff  = trial - {1'b0, den};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

>>> design/structure_factor_grid_accumulator_core.sv
// 2-d structure factor accumulator over a grid of wave-vector harmonics
// Each particle word walks all GRID_X*GRID_Y grid points through one shared
// phase, sine rom and multiply-add pipeline, one point per cycle, and the next
// particle is taken only once that pipeline has drained; a particle past
// MAX_PARTICLES is not accumulated and only sets the overflow flag. A particle
// marked last then reads out every grid point: each point passes through the one
// bit per cycle 64-bit power divider and then waits for the sink. Accumulators are
// cleared at once after the final grid point word is taken.
module structure_factor_grid_accumulator_core #(
  parameter int GRID_X        = 8,
  parameter int GRID_Y        = 8,
  parameter int MAX_PARTICLES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  sfga_in_if.sink     in_ch,
  sfga_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import sfga_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int OFS_X = (GRID_X - 1) / 2;
  localparam int OFS_Y = (GRID_Y - 1) / 2;

  state_t state_r, state_nxt;

  logic               mode_r;
  logic               pmode_r;
  logic [15:0]        px_r, py_r;
  logic signed [15:0] vx_r, vy_r;
  logic               plast_r;
  logic [CNT_W-1:0]   count_r;
  logic               ovf_r;
  logic [ACC_DEPTH-1:0] vld_r;

  logic [2:0]        i_r, j_r;
  logic [ACC_AW-1:0] idx_r;
  logic              pt_last;
  logic              in_acc;

  // accumulate pipeline
  logic              va_r, vb_r, vc_r, vd_r;
  logic [15:0]       ph_r;
  logic [ACC_AW-1:0] idx_b_r, idx_c_r, idx_d_r;
  logic [1:0]        q_c_r;
  logic signed [4:0] kx, ky;
  logic [15:0]       ph;
  logic [TIDX_W-1:0] tix;
  logic [QTAB_AW-1:0] addr_even, addr_odd, addr_s, addr_c;
  logic [14:0]       mag_s, mag_c;
  logic [1:0]        qc;
  logic signed [15:0] s_c, c_c, s_d_r, c_d_r;
  logic signed [31:0] p_xc_r, p_ys_r, p_xs_r, p_yc_r;
  logic              mode_d_r;
  logic signed [32:0] vre, vim;
  logic [ACC_W-1:0]  inc_re, inc_im, base_re, base_im;
  logic [ACC_W-1:0]  rd_re, rd_im;
  logic              ram_we;
  logic [ACC_AW-1:0] ram_raddr;

  // readout
  logic signed [ACC_W-1:0] ro_re, ro_im;
  logic [ACC_W-1:0]   re_r, im_r;
  logic [MAG_W-1:0]   sqre_r, sqim_r;
  logic               div_start;
  logic               div_done;
  logic [MAG_W-1:0]   quo;
  logic [2:0]         o_ix_r, o_iy_r;
  logic [ACC_W-1:0]   o_re_r, o_im_r;
  logic [POWER_W-1:0] o_pw_r;
  logic               o_ovf_r, o_last_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign pt_last = (i_r == 3'(GRID_X - 1)) && (j_r == 3'(GRID_Y - 1));
  assign in_acc = count_r < CNT_W'(MAX_PARTICLES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_acc) begin
            state_nxt = ST_ACC;
          end else if (in_ch.last_particle) begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_ACC: begin
        if (pt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(va_r || vb_r || vc_r || vd_r)) begin
          state_nxt = plast_r ? ST_RD : ST_IDLE;
        end
      end
      ST_RD:  state_nxt = ST_SQ;
      ST_SQ:  state_nxt = ST_SUM;
      ST_SUM: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = pt_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // frame state and grid counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= '0;
      ovf_r   <= 1'b0;
      vld_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (ram_we) begin
        vld_r[idx_d_r] <= 1'b1;
      end
      if (state_r == ST_IDLE && in_ch.valid) begin
        if (in_acc) begin
          count_r <= count_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (state_r == ST_ACC || (state_r == ST_OUT && out_ch.ready)) begin
        if (pt_last) begin
          i_r   <= '0;
          j_r   <= '0;
          idx_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
          if (j_r == 3'(GRID_Y - 1)) begin
            j_r <= '0;
            i_r <= i_r + 1'b1;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
      end
      if (state_r == ST_OUT && out_ch.ready && pt_last) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        vld_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      px_r    <= in_ch.pos_x;
      py_r    <= in_ch.pos_y;
      vx_r    <= in_ch.vel_x;
      vy_r    <= in_ch.vel_y;
      plast_r <= in_ch.last_particle;
      pmode_r <= mode_r;
    end
  end

  // stage a: phase in turns
  assign kx = 5'({2'b00, i_r}) - 5'(OFS_X);
  assign ky = 5'({2'b00, j_r}) - 5'(OFS_Y);
  assign ph = 16'(16'(kx) * px_r + 16'(ky) * py_r);

  // stage b: quadrant fold into rom addresses
  assign tix       = ph_r[13:TAB_SH];
  assign addr_even = QTAB_AW'(tix);
  assign addr_odd  = QTAB_AW'(QTAB_N - 1) - QTAB_AW'(tix);
  assign addr_s    = ph_r[14] ? addr_odd : addr_even;
  assign addr_c    = ph_r[14] ? addr_even : addr_odd;

  sfga_sine_rom u_rom (
    .clk    (clk),
    .addr_a (addr_s),
    .addr_b (addr_c),
    .data_a (mag_s),
    .data_b (mag_c)
  );

  // stage c: signs and velocity products
  assign qc  = q_c_r + 2'd1;
  assign s_c = q_c_r[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  assign c_c = qc[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

  // stage d: accumulate
  assign vre     = (33'(p_xc_r) + 33'(p_ys_r)) >>> 15;
  assign vim     = (33'(p_xs_r) - 33'(p_yc_r)) >>> 15;
  assign inc_re  = mode_d_r ? ACC_W'(vre) : ACC_W'(c_d_r);
  assign inc_im  = mode_d_r ? ACC_W'(vim) : ACC_W'(s_d_r);
  assign base_re = vld_r[idx_d_r] ? rd_re : '0;
  assign base_im = vld_r[idx_d_r] ? rd_im : '0;
  assign ram_we  = vc_r;
  assign ram_raddr = (state_r == ST_RD) ? idx_r : idx_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= (state_r == ST_ACC);
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    ph_r     <= ph;
    idx_b_r  <= idx_r;
    q_c_r    <= ph_r[15:14];
    idx_c_r  <= idx_b_r;
    idx_d_r  <= idx_c_r;
    s_d_r    <= s_c;
    c_d_r    <= c_c;
    p_xc_r   <= vx_r * c_c;
    p_ys_r   <= vy_r * s_c;
    p_xs_r   <= vx_r * s_c;
    p_yc_r   <= vy_r * c_c;
    mode_d_r <= pmode_r;
  end

  sfga_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc_re (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_d_r),
    .wdata (base_re + inc_re),
    .raddr (ram_raddr),
    .rdata (rd_re)
  );

  sfga_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc_im (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_d_r),
    .wdata (base_im + inc_im),
    .raddr (ram_raddr),
    .rdata (rd_im)
  );

  // readout path
  assign ro_re = vld_r[idx_r] ? rd_re : '0;
  assign ro_im = vld_r[idx_r] ? rd_im : '0;

  always_ff @(posedge clk) begin
    if (state_r == ST_SQ) begin
      re_r   <= ro_re;
      im_r   <= ro_im;
      sqre_r <= MAG_W'(ro_re * ro_re);
      sqim_r <= MAG_W'(ro_im * ro_im);
    end
  end

  sfga_div #(.DEN_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sqre_r + sqim_r),
    .den   (count_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_done) begin
      o_ix_r   <= i_r;
      o_iy_r   <= j_r;
      o_re_r   <= re_r;
      o_im_r   <= im_r;
      o_ovf_r  <= ovf_r;
      o_last_r <= pt_last;
      if (count_r == '0) begin
        o_pw_r <= '0;
      end else if (quo > POWER_MAX) begin
        o_pw_r <= POWER_MAX[POWER_W-1:0];
      end else begin
        o_pw_r <= quo[POWER_W-1:0];
      end
    end
  end

  assign out_ch.valid    = (state_r == ST_OUT);
  assign out_ch.grid_ix  = o_ix_r;
  assign out_ch.grid_iy  = o_iy_r;
  assign out_ch.sum_re   = o_re_r;
  assign out_ch.sum_im   = o_im_r;
  assign out_ch.power    = o_pw_r;
  assign out_ch.overflow = o_ovf_r;
  assign out_ch.last     = o_last_r;

endmodule

>>> sim/tb_structure_factor_grid_accumulator_core.sv
// testbench for the structure factor grid accumulator core
`timescale 1ns / 1ps

module tb_structure_factor_grid_accumulator_core;

  localparam int NX          = 8;
  localparam int NY          = 8;
  localparam int MAX_PART    = 4096;
  localparam int SETTLE      = 200;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic [59:0] POWER_SAT = 60'hFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  ix;
    logic [2:0]  iy;
    logic [31:0] re;
    logic [31:0] im;
    logic [59:0] pw;
    logic        ovf;
    logic        lst;
  } grid_point_t;

  class sfactor_scoreboard;
    logic [31:0] acc_re [64];
    logic [31:0] acc_im [64];
    int          count;
    bit          ovf;
    bit          vmode;
    grid_point_t pending_points [$];
    int          mismatches;

    function new();
      clear();
      vmode = 0;
      mismatches = 0;
    endfunction

    function void clear();
      foreach (acc_re[n]) begin
        acc_re[n] = 0;
        acc_im[n] = 0;
      end
      count = 0;
      ovf = 0;
    endfunction

    function longint quarter_wave(longint unsigned t);
      longint unsigned theta, th2, term, s, q;
      longint unsigned divs [5];
      divs = '{110, 72, 42, 20, 6};
      theta = (t * 64'd6746518852) >> 16;
      th2 = (theta * theta) >> 30;
      term = 64'd1073741824;
      for (int k = 0; k < 5; k++) begin
        term = 64'd1073741824 - ((th2 * term) >> 30) / divs[k];
      end
      s = (theta * term) >> 30;
      q = (s + 64'd16384) >> 15;
      if (q > 32767) begin
        q = 32767;
      end
      return longint'(q);
    endfunction

    function longint table_sin(logic [15:0] ph);
      logic [15:0] a;
      logic [1:0]  quad;
      longint unsigned t;
      longint      mag;
      a = (ph >> 4) << 4;
      quad = a[15:14];
      t = a[13:0];
      if (quad[0]) begin
        t = 16384 - t;
      end
      mag = quarter_wave(t);
      return quad[1] ? -mag : mag;
    endfunction

    function void note_particle(logic [15:0] px, logic [15:0] py,
                                logic signed [15:0] vx, logic signed [15:0] vy,
                                bit lst);
      int          kx, ky, idx;
      logic [15:0] ph;
      longint      s, c, re, im, sre, sim;
      longint unsigned mag;
      grid_point_t gp;
      if (count >= MAX_PART) begin
        ovf = 1;
      end else begin
        for (int i = 0; i < NX; i++) begin
          for (int j = 0; j < NY; j++) begin
            kx = i - (NX - 1) / 2;
            ky = j - (NY - 1) / 2;
            ph = 16'(kx * int'(px) + ky * int'(py));
            s = table_sin(ph);
            c = table_sin(ph + 16'd16384);
            if (vmode) begin
              re = (longint'(vx) * c + longint'(vy) * s) >>> 15;
              im = (longint'(vx) * s - longint'(vy) * c) >>> 15;
            end else begin
              re = c;
              im = s;
            end
            idx = i * NY + j;
            acc_re[idx] += re[31:0];
            acc_im[idx] += im[31:0];
          end
        end
        count++;
      end
      if (!lst) begin
        return;
      end
      for (int i = 0; i < NX; i++) begin
        for (int j = 0; j < NY; j++) begin
          idx = i * NY + j;
          sre = longint'($signed(acc_re[idx]));
          sim = longint'($signed(acc_im[idx]));
          mag = longint'(sre * sre) + longint'(sim * sim);
          mag = (count != 0) ? mag / longint'(count) : 0;
          gp.ix = i[2:0];
          gp.iy = j[2:0];
          gp.re = acc_re[idx];
          gp.im = acc_im[idx];
          gp.pw = (mag > POWER_SAT) ? POWER_SAT : mag[59:0];
          gp.ovf = ovf;
          gp.lst = (idx == NX * NY - 1);
          pending_points.push_back(gp);
        end
      end
      clear();
    endfunction

    function void check_point(grid_point_t got);
      grid_point_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected grid point word ix=%0d iy=%0d", got.ix, got.iy);
        end
        return;
      end
      want = pending_points.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp ix=%0d iy=%0d re=%0d im=%0d pw=%0d ovf=%0b last=%0b",
                   want.ix, want.iy, $signed(want.re), $signed(want.im), want.pw,
                   want.ovf, want.lst);
          $display("         got ix=%0d iy=%0d re=%0d im=%0d pw=%0d ovf=%0b last=%0b",
                   got.ix, got.iy, $signed(got.re), $signed(got.im), got.pw,
                   got.ovf, got.lst);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   idle_phase;
  int   cycles;

  sfga_in_if  in_ch ();
  sfga_out_if out_ch ();

  sfactor_scoreboard sb = new();

  structure_factor_grid_accumulator_core #(
    .GRID_X(NX),
    .GRID_Y(NY),
    .MAX_PARTICLES(MAX_PART)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic bit sender_idles();
    case (idle_phase)
      0: return $urandom_range(99, 0) < 18;
      1: return $urandom_range(99, 0) < 63;
      default: return 0;
    endcase
  endfunction

  function automatic bit receiver_idles();
    case (idle_phase)
      0: return $urandom_range(99, 0) < 63;
      1: return $urandom_range(99, 0) < 18;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      out_ch.ready <= !receiver_idles();
    end
  end

  always @(posedge clk) begin
    grid_point_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ix = out_ch.grid_ix;
      got.iy = out_ch.grid_iy;
      got.re = out_ch.sum_re;
      got.im = out_ch.sum_im;
      got.pw = out_ch.power;
      got.ovf = out_ch.overflow;
      got.lst = out_ch.last;
      sb.check_point(got);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_particle(logic [15:0] px, logic [15:0] py,
                               logic [15:0] vx, logic [15:0] vy, bit lst);
    @(negedge clk);
    while (sender_idles()) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.vel_x <= vx;
    in_ch.vel_y <= vy;
    in_ch.last_particle <= lst;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sb.note_particle(px, py, vx, vy, lst);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.vmode = m;
  endtask

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(7, 0))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_frame(int len);
    for (int k = 0; k < len; k++) begin
      send_particle(16'($urandom()), 16'($urandom()), rand_vel(), rand_vel(), k == len - 1);
    end
  endtask

  initial begin
    int sent;
    int len;
    cycles = 0;
    idle_phase = 2;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.last_particle = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: single and three particle frames, field extremes, both modes
    send_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1);
    send_particle(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 1);
    send_particle(16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 0);
    send_particle(16'h2000, 16'h0010, 16'h1234, 16'hFEDC, 0);
    send_particle(16'h8000, 16'h000F, 16'hFFFF, 16'h0001, 1);
    drain();
    set_mode(1);
    send_particle(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1);
    send_particle(16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 1);
    send_particle(16'h4000, 16'hFFFF, 16'h7FFF, 16'h8000, 0);
    send_particle(16'hC000, 16'h8000, 16'h8000, 16'h7FFF, 0);
    send_particle(16'h1111, 16'hEEEE, 16'hFFFF, 16'h0001, 1);
    drain();

    // random frames across three idle phases
    sent = 0;
    while (sent < 437) begin
      idle_phase = (sent < 150) ? 0 : (sent < 300) ? 1 : 2;
      len = ($urandom_range(5, 0) == 0) ? 1 : $urandom_range(30, 5);
      random_frame(len);
      sent += len;
      if ($urandom_range(3, 0) == 0) begin
        drain();
        set_mode($urandom_range(1, 0));
      end
    end
    drain();

    idle_phase = 2;
    set_mode(1);
    random_frame(3);
    drain();

    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> structure_factor_grid_accumulator_core.f
design/sfga_pkg.sv
design/sfga_if.sv
design/sfga_ram.sv
design/sfga_sine_rom.sv
design/sfga_div.sv
design/structure_factor_grid_accumulator_core.sv
sim/tb_structure_factor_grid_accumulator_core.sv
